>>> hw/rtl/fdr_pkg.sv
// Shared definitions for the fractional divider ratio unit.
// Holds field widths, command and divider operand codes, and the control/status structs.
// Depends on nothing; every other file of the block but fdr_serial_div refers to it by scoped names.
package fdr_pkg;

    // Default width in which the rates are taken.
    localparam int RATE_BITS_DEF = 32;

    // Widths fixed by the word format.
    localparam int IN_RATE_W = 32;
    localparam int FACTOR_W  = 32;
    localparam int FIELD_W   = 16;
    localparam int OUT_W     = 48;

    // Command codes carried by the cmd field.
    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_GET = 1'b1;

    // Operand selections for the shared serial divider.
    localparam logic [1:0] DSEL_MOD  = 2'd0;  // x mod y during the Euclid loop
    localparam logic [1:0] DSEL_DEN  = 2'd1;  // parent / gcd
    localparam logic [1:0] DSEL_NUM  = 2'd2;  // target / gcd
    localparam logic [1:0] DSEL_RATE = 2'd3;  // product / denominator

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       gcd_step;
        logic       div_start;
        logic [1:0] div_sel;
        logic       store_den;
        logic       store_factor;
        logic       load_prod;
        logic       store_rate;
        logic       out_load;
        logic       out_err;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cmd_get;
        logic x_zero;
        logic y_zero;
        logic den_zero;
        logic div_done;
    } dp_stat_t;

endpackage

>>> hw/rtl/fractional_divider_ratio_unit.sv
// Fractional divider ratio unit: one word is worked on at a time, and the input stalls until
// the present word has moved into the output register. D = min(RATE_BITS, 32) + 16 (48 by
// default) is the dividend width of the serial divider. A get takes one division; a set takes
// one per Euclid remainder step and two more; an error found at the first check takes none.
// Reset clears the factor register, the controller and the output valid flag.
module fractional_divider_ratio_unit #(
    parameter int RATE_BITS = fdr_pkg::RATE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [fdr_pkg::IN_RATE_W-1:0] parent_rate,
    input  logic [fdr_pkg::IN_RATE_W-1:0] target_rate,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fdr_pkg::FACTOR_W-1:0]  factor_word,
    output logic [fdr_pkg::OUT_W-1:0]     output_rate,
    output logic                          div_error
);

    fdr_pkg::dp_cmd_t  ctl;
    fdr_pkg::dp_stat_t stat;

    // Sequencer and handshakes.
    fdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Registers, multiplier and divider.
    fdr_datapath #(
        .RATE_BITS (RATE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cmd         (cmd),
        .parent_rate (parent_rate),
        .target_rate (target_rate),
        .factor_word (factor_word),
        .output_rate (output_rate),
        .div_error   (div_error)
    );

endmodule

>>> hw/rtl/fdr_serial_div.sv
// Restoring serial divider: one quotient bit per cycle.
// Gives quotient and remainder, with a one-cycle done pulse. Uses no package items.
module fdr_serial_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient,
    output logic [DEN_W-1:0] remainder
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] dvs_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        shifted  = {rem_reg, quot_reg[NUM_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = (shifted >= {1'b0, dvs_reg});
        rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end

    // Control: the counter runs over every dividend bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Operand and result registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

>>> hw/rtl/fdr_datapath.sv
// Datapath of the fractional divider ratio unit: operand registers, factor register,
// multiplier, shared serial divider and the output word register.
// Depends on fdr_pkg and fdr_serial_div.
module fdr_datapath #(
    parameter int RATE_BITS = fdr_pkg::RATE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fdr_pkg::dp_cmd_t              ctl,
    output fdr_pkg::dp_stat_t             stat,
    input  logic                          cmd,
    input  logic [fdr_pkg::IN_RATE_W-1:0] parent_rate,
    input  logic [fdr_pkg::IN_RATE_W-1:0] target_rate,
    output logic [fdr_pkg::FACTOR_W-1:0]  factor_word,
    output logic [fdr_pkg::OUT_W-1:0]     output_rate,
    output logic                          div_error
);

    // Rates are taken in their low RATE_BITS bits, at most the input width.
    localparam int RW = (RATE_BITS < fdr_pkg::IN_RATE_W) ? RATE_BITS : fdr_pkg::IN_RATE_W;
    localparam int FW = fdr_pkg::FIELD_W;
    localparam int DW = RW + FW;

    logic [RW-1:0]                  p_reg;
    logic [RW-1:0]                  t_reg;
    logic [RW-1:0]                  x_reg;
    logic [RW-1:0]                  y_reg;
    logic                           cmd_reg;
    logic [FW-1:0]                  den_reg;
    logic [fdr_pkg::FACTOR_W-1:0]   factor_reg;
    logic [DW-1:0]                  prod_reg;
    logic [DW-1:0]                  rate_reg;
    logic [fdr_pkg::FACTOR_W-1:0]   out_factor_reg;
    logic [fdr_pkg::OUT_W-1:0]      out_rate_reg;
    logic                           out_err_reg;

    logic [RW-1:0] p_in;
    logic [RW-1:0] t_in;
    logic [RW-1:0] t_eff;
    logic [DW-1:0] prod_next;
    logic [DW-1:0] div_dividend;
    logic [RW-1:0] div_divisor;
    logic [DW-1:0] div_quot;
    logic [RW-1:0] div_rem;
    logic          div_done;

    // Incoming rates, with a zero target standing for the parent rate.
    assign p_in  = parent_rate[RW-1:0];
    assign t_in  = target_rate[RW-1:0];
    assign t_eff = (t_in == '0) ? p_in : t_in;

    // Parent rate times the stored numerator.
    assign prod_next = DW'(p_reg) * DW'(factor_reg[fdr_pkg::FACTOR_W-1:FW]);

    // Operand selection for the shared divider.
    always_comb
    begin
        unique case (ctl.div_sel)
            fdr_pkg::DSEL_MOD:
            begin
                div_dividend = DW'(x_reg);
                div_divisor  = y_reg;
            end
            fdr_pkg::DSEL_DEN:
            begin
                div_dividend = DW'(p_reg);
                div_divisor  = x_reg;
            end
            fdr_pkg::DSEL_NUM:
            begin
                div_dividend = DW'(t_reg);
                div_divisor  = x_reg;
            end
            fdr_pkg::DSEL_RATE:
            begin
                div_dividend = prod_reg;
                div_divisor  = RW'(factor_reg[FW-1:0]);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    fdr_serial_div #(
        .NUM_W (DW),
        .DEN_W (RW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // The factor register is architectural state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= '0;
        end
        else if (ctl.store_factor)
        begin
            factor_reg <= {div_quot[FW-1:0], den_reg};
        end
    end

    // Working registers for the Euclid loop, the product and the rate.
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            p_reg    <= p_in;
            t_reg    <= t_eff;
            x_reg    <= p_in;
            y_reg    <= t_eff;
            cmd_reg  <= cmd;
            rate_reg <= '0;
        end
        else
        begin
            if (ctl.gcd_step)
            begin
                x_reg <= y_reg;
                y_reg <= div_rem;
            end
            if (ctl.store_rate)
            begin
                rate_reg <= div_quot;
            end
        end
        if (ctl.store_den)
        begin
            den_reg <= div_quot[FW-1:0];
        end
        if (ctl.load_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_factor_reg <= factor_reg;
            out_rate_reg   <= fdr_pkg::OUT_W'(rate_reg);
            out_err_reg    <= ctl.out_err;
        end
    end

    always_comb
    begin
        stat.cmd_get  = (cmd_reg == fdr_pkg::CMD_GET);
        stat.x_zero   = (x_reg == '0);
        stat.y_zero   = (y_reg == '0);
        stat.den_zero = (factor_reg[FW-1:0] == '0);
        stat.div_done = div_done;
    end

    assign factor_word = out_factor_reg;
    assign output_rate = out_rate_reg;
    assign div_error   = out_err_reg;

endmodule

>>> hw/rtl/fdr_ctrl.sv
// Controller of the fractional divider ratio unit: sequences the Euclid loop, the
// reductions and the rate division, and runs both handshakes. Depends on fdr_pkg.
module fdr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  fdr_pkg::dp_stat_t   stat,
    output fdr_pkg::dp_cmd_t    ctl
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CHECK     = 3'd1;
    localparam logic [2:0] S_GCD_WAIT  = 3'd2;
    localparam logic [2:0] S_DEN_WAIT  = 3'd3;
    localparam logic [2:0] S_NUM_WAIT  = 3'd4;
    localparam logic [2:0] S_MUL       = 3'd5;
    localparam logic [2:0] S_RATE_WAIT = 3'd6;
    localparam logic [2:0] S_FINISH    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       err_reg;
    logic       err_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Next state and datapath commands.
    always_comb
    begin
        state_next       = state_reg;
        err_next         = err_reg;
        out_valid_next   = out_valid_reg && out_stall;
        ctl              = '0;
        ctl.div_sel      = fdr_pkg::DSEL_MOD;
        ctl.out_err      = err_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctl.load_in = 1'b1;
                    err_next    = 1'b0;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.cmd_get)
                begin
                    if (stat.den_zero)
                    begin
                        err_next   = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        ctl.load_prod = 1'b1;
                        state_next    = S_MUL;
                    end
                end
                else if (stat.y_zero)
                begin
                    // The gcd sits in x; zero means both rates were zero.
                    if (stat.x_zero)
                    begin
                        err_next   = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        ctl.div_start = 1'b1;
                        ctl.div_sel   = fdr_pkg::DSEL_DEN;
                        state_next    = S_DEN_WAIT;
                    end
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = fdr_pkg::DSEL_MOD;
                    state_next    = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT:
            begin
                if (stat.div_done)
                begin
                    ctl.gcd_step = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_DEN_WAIT:
            begin
                if (stat.div_done)
                begin
                    ctl.store_den = 1'b1;
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = fdr_pkg::DSEL_NUM;
                    state_next    = S_NUM_WAIT;
                end
            end
            S_NUM_WAIT:
            begin
                if (stat.div_done)
                begin
                    ctl.store_factor = 1'b1;
                    state_next       = S_FINISH;
                end
            end
            S_MUL:
            begin
                ctl.div_start = 1'b1;
                ctl.div_sel   = fdr_pkg::DSEL_RATE;
                state_next    = S_RATE_WAIT;
            end
            S_RATE_WAIT:
            begin
                ctl.div_sel = fdr_pkg::DSEL_RATE;
                if (stat.div_done)
                begin
                    ctl.store_rate = 1'b1;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Hand the word over once the output register is free.
                if (out_free)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
